FILE: rtl/kop_pkg.sv
`default_nettype none
package kop_pkg;

   // Angle resolution of the Kepler iteration, in bits per turn
   localparam int ANGLE_BITS     = 24;
   localparam int MAX_ITERATIONS = 32;
   localparam int ITER_CNT_BITS  = $clog2(MAX_ITERATIONS);

   // Long division of time by period: 32 remainder steps, then the fraction bits
   localparam int DIV_STEPS    = 32 + ANGLE_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

   localparam logic [30:0] Q30_ONE        = 31'd1073741824;
   localparam logic [30:0] SC1            = 31'd1686629713;
   localparam logic [30:0] SC3            = 31'd693598668;
   localparam logic [30:0] SC5            = 31'd85569306;
   localparam logic [30:0] SC7            = 31'd5026995;
   localparam logic [30:0] SC9            = 31'd172272;
   localparam logic [30:0] SC11           = 31'd3864;
   localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;
   localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

   localparam logic [23:0] SEMI_MAJOR_AXIS_RESET = 24'd884736;
   localparam logic [15:0] ECCENTRICITY_RESET    = 16'd0;
   localparam logic [31:0] ORBITAL_PERIOD_RESET  = 32'd1097728;
   localparam logic [15:0] ROTATION_ANGLE_RESET  = 16'd0;

   typedef logic [ANGLE_BITS-1:0] angle_type;

   typedef enum logic [1:0] {
      CSR_SEMI_MAJOR_AXIS = 2'd0,
      CSR_ECCENTRICITY    = 2'd1,
      CSR_ORBITAL_PERIOD  = 2'd2,
      CSR_ROTATION_ANGLE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [23:0] semi_major_axis;
      logic [15:0] eccentricity;
      logic [31:0] orbital_period;
      logic [15:0] rotation_angle;
   } cfg_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [4:0] {
      B_IDLE,
      B_SQRT,
      B_ITER,
      B_SIN_Z2,
      B_SIN_HORN,
      B_SIN_OUT,
      B_STEP1,
      B_STEP2,
      B_COSE,
      B_SINE,
      B_COSR,
      B_SINR,
      B_YM,
      B_U1,
      B_U2,
      B_XF,
      B_DONE
   } back_state_type;

   typedef enum logic [2:0] {
      J_ITER,
      J_COSE,
      J_SINE,
      J_COSR,
      J_SINR
   } sine_job_type;

   // Horner coefficients of the sine polynomial, highest order first after z^11
   function automatic logic [30:0] horner_coef(input logic [2:0] k);
      logic [30:0] c;
      case (k)
         3'd0:    c = SC9;
         3'd1:    c = SC7;
         3'd2:    c = SC5;
         3'd3:    c = SC3;
         default: c = SC1;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/kepler_orbit_position_unit.sv
`default_nettype none
// Kepler orbit position unit: each sample_time transaction yields one transaction with the
// rotated x coordinate of a body on a Kepler ellipse and a converged flag. A front divider
// forms the mean anomaly (one quotient bit a cycle) and hands it through a two-entry queue
// to a back sequencer built around one shared 32x32 multiplier. The back end sets the
// sustained rate; its work per transaction grows with k (1 to 32), the number of Kepler
// iterations. Registers must be written only while the unit is idle, which it does not enforce.
module kepler_orbit_position_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [31:0]        req_sample_time,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [26:0]      rsp_x_position,
   output logic                    rsp_converged
);
   import kop_pkg::*;

   cfg_type   cfg_ff;
   logic      fifo_push, fifo_pop, fifo_full, fifo_empty;
   angle_type push_data, pop_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.semi_major_axis <= SEMI_MAJOR_AXIS_RESET;
         cfg_ff.eccentricity    <= ECCENTRICITY_RESET;
         cfg_ff.orbital_period  <= ORBITAL_PERIOD_RESET;
         cfg_ff.rotation_angle  <= ROTATION_ANGLE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_SEMI_MAJOR_AXIS: cfg_ff.semi_major_axis <= csr_write_data[23:0];
            CSR_ECCENTRICITY:    cfg_ff.eccentricity    <= csr_write_data[15:0];
            CSR_ORBITAL_PERIOD:  cfg_ff.orbital_period  <= csr_write_data;
            CSR_ROTATION_ANGLE:  cfg_ff.rotation_angle  <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   kop_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample_time (req_sample_time),
      .period          (cfg_ff.orbital_period),
      .push            (fifo_push),
      .push_data       (push_data),
      .fifo_full       (fifo_full)
   );

   kop_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .empty     (fifo_empty)
   );

   kop_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .fifo_empty     (fifo_empty),
      .pop            (fifo_pop),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_x_position (rsp_x_position),
      .rsp_converged  (rsp_converged)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> !fifo_full) else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      fifo_pop |-> !fifo_empty) else $error("queue read while empty");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall) else $error("front not busy after accept");

endmodule
`default_nettype wire

FILE: rtl/kop_front.sv
`default_nettype none
module kop_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [31:0]         req_sample_time,
   input  wire logic [31:0]         period,
   output logic                     push,
   output kop_pkg::angle_type       push_data,
   input  wire logic                fifo_full
);
   import kop_pkg::*;

   front_state_type          state_ff, state_in;
   logic [31:0]              rem_ff;
   logic [31:0]              dvd_ff;
   angle_type                q_ff;
   logic [DIV_CNT_BITS-1:0]  cnt_ff;

   logic [32:0] rem_sh;
   logic [32:0] rem_sub;
   logic        fits;

   // One restoring division step: shift in the next dividend bit
   assign rem_sh  = {rem_ff, dvd_ff[31]};
   assign fits    = rem_sh >= {1'b0, period};
   assign rem_sub = rem_sh - {1'b0, period};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (req_valid) state_in = F_DIV;
         F_DIV:  if (cnt_ff == DIV_CNT_BITS'(DIV_STEPS - 1)) state_in = F_PUSH;
         F_PUSH: if (!fifo_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   // Outputs: a zero period gives a zero mean anomaly
   always_comb begin
      req_stall = (state_ff != F_IDLE);
      push      = (state_ff == F_PUSH) && !fifo_full;
      push_data = (period == 32'd0) ? '0 : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Divider datapath
   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE) begin
         dvd_ff <= req_sample_time;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (state_ff == F_DIV) begin
         rem_ff <= fits ? rem_sub[31:0] : rem_sh[31:0];
         dvd_ff <= {dvd_ff[30:0], 1'b0};
         q_ff   <= {q_ff[ANGLE_BITS-2:0], fits};
         cnt_ff <= cnt_ff + DIV_CNT_BITS'(1);
      end
   end

endmodule
`default_nettype wire

FILE: rtl/kop_fifo.sv
`default_nettype none
module kop_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire kop_pkg::angle_type  push_data,
   output logic                     full,
   input  wire logic                pop,
   output kop_pkg::angle_type       pop_data,
   output logic                     empty
);
   import kop_pkg::*;

   angle_type   mem_ff [2];
   logic        wr_ff;
   logic        rd_ff;
   logic [1:0]  count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rd_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         if (push && !pop)      count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // Store entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: rtl/kop_back.sv
`default_nettype none
module kop_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kop_pkg::cfg_type          cfg,
   input  wire logic                      fifo_empty,
   output logic                           pop,
   input  wire kop_pkg::angle_type        pop_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic signed [26:0]             rsp_x_position,
   output logic                           rsp_converged
);
   import kop_pkg::*;

   back_state_type            state_ff, state_in;
   sine_job_type              job_ff;
   angle_type                 m_ff, e_ff;
   logic [ITER_CNT_BITS-1:0]  iter_ff;
   logic [16:0]               root_ff;
   logic [4:0]                sq_bit_ff;
   logic [31:0]               ang_ff;
   logic [30:0]               z2_ff, p_ff;
   logic [2:0]                horn_ff;
   logic [30:0]               smag_ff;
   logic                      sneg_ff;
   logic [29:0]               mag1_ff;
   logic signed [31:0]        ce_ff, se_ff, cr_ff, sr_ff, ym_ff;
   logic signed [32:0]        t1_ff;
   logic signed [33:0]        u_ff;
   logic                      conv_ff;
   logic signed [26:0]        x_ff;
   logic                      rsp_valid_ff;
   logic signed [26:0]        rsp_x_ff;
   logic                      rsp_conv_ff;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        prod;
   logic [63:0]        prod_h30, prod_h16, dsum;
   logic [33:0]        r30;
   logic [30:0]        z;
   logic [33:0]        s_raw;
   logic [30:0]        s_clamp;
   logic signed [31:0] s_val;
   logic [30:0]        p_next;
   angle_type          d, en;
   logic [32:0]        sq_val;
   logic [16:0]        trial;
   logic [33:0]        trial_sq;
   logic signed [31:0] xm;
   logic [31:0]        xm_abs, cr_abs, se_abs, ym_abs, sr_abs, u_abs;
   logic signed [32:0] t_signed;
   logic signed [33:0] u_next;
   logic [33:0]        x_mag;
   logic signed [26:0] x_sat;
   logic [31:0]        e_turn;
   logic               load;

   // Sine argument folded to the first quadrant, Q30
   assign z = ang_ff[30] ? (Q30_ONE - {1'b0, ang_ff[29:0]}) : {1'b0, ang_ff[29:0]};

   // Shared multiplier with its renormalizing adders
   assign prod     = 64'(mul_a) * 64'(mul_b);
   assign prod_h30 = prod + 64'h2000_0000;
   assign prod_h16 = prod + 64'h8000;
   assign r30      = prod_h30[63:30];
   assign s_raw    = prod[63:30];
   assign s_clamp  = (s_raw > {3'b0, Q30_ONE}) ? Q30_ONE : s_raw[30:0];
   assign s_val    = ang_ff[31] ? -$signed({1'b0, s_clamp}) : $signed({1'b0, s_clamp});
   assign p_next   = horner_coef(horn_ff) - prod[60:30];

   // Kepler step from e*sin(E)/(2*pi)
   assign dsum = prod + (64'd1 << (61 - ANGLE_BITS));
   assign d    = ANGLE_BITS'(dsum >> (62 - ANGLE_BITS));
   assign en   = sneg_ff ? (m_ff - d) : (m_ff + d);

   // Root of 1 - e^2, one bit per cycle
   assign sq_val   = 33'h1_0000_0000 - 33'(32'(cfg.eccentricity) * 32'(cfg.eccentricity));
   assign trial    = root_ff | (17'd1 << sq_bit_ff);
   assign trial_sq = 34'(trial) * 34'(trial);

   // Magnitudes for sign-magnitude products
   assign xm     = ce_ff - $signed({2'b00, cfg.eccentricity, 14'b0});
   assign xm_abs = xm[31] ? 32'(-xm) : 32'(xm);
   assign cr_abs = cr_ff[31] ? 32'(-cr_ff) : 32'(cr_ff);
   assign se_abs = se_ff[31] ? 32'(-se_ff) : 32'(se_ff);
   assign ym_abs = ym_ff[31] ? 32'(-ym_ff) : 32'(ym_ff);
   assign sr_abs = sr_ff[31] ? 32'(-sr_ff) : 32'(sr_ff);
   assign u_abs  = u_ff[33] ? 32'(-u_ff) : 32'(u_ff);

   assign t_signed = (xm[31] ^ cr_ff[31]) ? -$signed({1'b0, r30[31:0]})
                                          : $signed({1'b0, r30[31:0]});
   assign u_next   = ((ym_ff[31] ^ sr_ff[31]) ? 34'(t1_ff) + 34'(r30[30:0])
                                               : 34'(t1_ff) - 34'(r30[30:0]));

   // Saturate the final product
   assign x_mag = r30;
   always_comb begin
      if (u_ff[33]) begin
         x_sat = (x_mag > 34'd67108864) ? -27'sd67108864 : 27'(-$signed({1'b0, x_mag}));
      end else begin
         x_sat = (x_mag > 34'd67108863) ? 27'sd67108863 : 27'(x_mag);
      end
   end

   assign e_turn = 32'(e_ff) << (32 - ANGLE_BITS);
   assign load   = (state_ff == B_DONE) && (!rsp_valid_ff || !rsp_stall);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE:     if (!fifo_empty) state_in = B_SQRT;
         B_SQRT:     if (sq_bit_ff == 5'd0) state_in = B_ITER;
         B_ITER:     state_in = B_SIN_Z2;
         B_SIN_Z2:   state_in = B_SIN_HORN;
         B_SIN_HORN: if (horn_ff == 3'd4) state_in = B_SIN_OUT;
         B_SIN_OUT: begin
            unique case (job_ff)
               J_ITER:  state_in = B_STEP1;
               J_COSE:  state_in = B_SINE;
               J_SINE:  state_in = B_COSR;
               J_COSR:  state_in = B_SINR;
               J_SINR:  state_in = B_YM;
               default: state_in = B_YM;
            endcase
         end
         B_STEP1:    state_in = B_STEP2;
         B_STEP2: begin
            if (en == e_ff || iter_ff == ITER_CNT_BITS'(MAX_ITERATIONS - 1)) begin
               state_in = B_COSE;
            end else begin
               state_in = B_ITER;
            end
         end
         B_COSE, B_SINE, B_COSR, B_SINR: state_in = B_SIN_Z2;
         B_YM:       state_in = B_U1;
         B_U1:       state_in = B_U2;
         B_U2:       state_in = B_XF;
         B_XF:       state_in = B_DONE;
         B_DONE:     if (load) state_in = B_IDLE;
         default:    state_in = B_IDLE;
      endcase
   end

   // Outputs: queue pop and multiplier operands
   always_comb begin
      pop   = (state_ff == B_IDLE) && !fifo_empty;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         B_SIN_Z2:   begin mul_a = 32'(z);               mul_b = 32'(z);       end
         B_SIN_HORN: begin mul_a = 32'(p_ff);            mul_b = 32'(z2_ff);   end
         B_SIN_OUT:  begin mul_a = 32'(p_ff);            mul_b = 32'(z);       end
         B_STEP1:    begin mul_a = 32'(cfg.eccentricity); mul_b = 32'(smag_ff); end
         B_STEP2:    begin mul_a = 32'(mag1_ff);         mul_b = INV_TWO_PI_Q32; end
         B_YM:       begin mul_a = se_abs;               mul_b = 32'(root_ff); end
         B_U1:       begin mul_a = xm_abs;               mul_b = cr_abs;       end
         B_U2:       begin mul_a = ym_abs;               mul_b = sr_abs;       end
         B_XF:       begin mul_a = 32'(cfg.semi_major_axis); mul_b = u_abs;    end
         default:    begin mul_a = '0;                   mul_b = '0;           end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Sequencer datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            m_ff      <= pop_data;
            e_ff      <= pop_data;
            iter_ff   <= '0;
            root_ff   <= '0;
            sq_bit_ff <= 5'd16;
         end
         B_SQRT: begin
            if (trial_sq <= {1'b0, sq_val}) root_ff <= trial;
            sq_bit_ff <= sq_bit_ff - 5'd1;
         end
         B_ITER: begin
            ang_ff <= e_turn;
            job_ff <= J_ITER;
         end
         B_COSE: begin
            ang_ff <= e_turn + QUARTER_TURN;
            job_ff <= J_COSE;
         end
         B_SINE: begin
            ang_ff <= e_turn;
            job_ff <= J_SINE;
         end
         B_COSR: begin
            ang_ff <= {cfg.rotation_angle, 16'b0} + QUARTER_TURN;
            job_ff <= J_COSR;
         end
         B_SINR: begin
            ang_ff <= {cfg.rotation_angle, 16'b0};
            job_ff <= J_SINR;
         end
         B_SIN_Z2: begin
            z2_ff   <= prod[60:30];
            p_ff    <= SC11;
            horn_ff <= 3'd0;
         end
         B_SIN_HORN: begin
            p_ff    <= p_next;
            horn_ff <= horn_ff + 3'd1;
         end
         B_SIN_OUT: begin
            smag_ff <= s_clamp;
            sneg_ff <= ang_ff[31];
            case (job_ff)
               J_COSE:  ce_ff <= s_val;
               J_SINE:  se_ff <= s_val;
               J_COSR:  cr_ff <= s_val;
               J_SINR:  sr_ff <= s_val;
               default: ;
            endcase
         end
         B_STEP1: mag1_ff <= prod_h16[45:16];
         B_STEP2: begin
            conv_ff <= (en == e_ff);
            e_ff    <= en;
            iter_ff <= iter_ff + ITER_CNT_BITS'(1);
         end
         B_YM: ym_ff <= se_ff[31] ? -$signed({1'b0, prod_h16[46:16]})
                                  : $signed({1'b0, prod_h16[46:16]});
         B_U1: t1_ff <= t_signed;
         B_U2: u_ff  <= u_next;
         B_XF: x_ff  <= x_sat;
         default: ;
      endcase
   end

   // Hold the result until taken
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_x_ff    <= x_ff;
         rsp_conv_ff <= conv_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_x_position = rsp_x_ff;
   assign rsp_converged  = rsp_conv_ff;

endmodule
`default_nettype wire
